// File: sv/paging_thrash_level_monitor_unit_macros.svh
`ifndef PAGING_THRASH_LEVEL_MONITOR_UNIT_MACROS_SVH
`define PAGING_THRASH_LEVEL_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PTL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PTL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ptl_pkg.sv
package ptl_pkg;

	localparam int INTEG_W = 64;

	typedef enum logic [1:0] {
		ACT_PAGE_START = 2'd0,
		ACT_PAGE_END   = 2'd1,
		ACT_UPDATE     = 2'd2,
		ACT_RESTART    = 2'd3
	} action_t;

	localparam logic [1:0] CFG_IDX_THRASH = 2'd0;
	localparam logic [1:0] CFG_IDX_GOOD   = 2'd1;

	localparam logic [7:0] THR_THRASH_RST = 8'd200;
	localparam logic [7:0] THR_GOOD_RST   = 8'd150;
	localparam logic [7:0] ACT_SATURATED  = 8'd255;

	typedef struct packed {
		logic [INTEG_W-1:0] a;
		logic [INTEG_W-1:0] b;
		logic               cin;
	} alu_req_t;

	typedef struct packed {
		logic [INTEG_W-1:0] sum;
		logic               carry;
	} alu_rsp_t;

	typedef struct packed {
		logic [7:0] thr_thrash;
		logic [7:0] thr_good;
	} thr_cfg_t;

	typedef struct packed {
		logic       underflow;
		logic [7:0] activity;
		logic       notify;
		logic       thrashing;
		logic [7:0] level;
	} ptl_res_t;

endpackage

// File: sv/ptl_alu.sv
module ptl_alu
	import ptl_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [INTEG_W:0] full_sum;

	// A subtraction is requested as a + ~b + 1; the carry out is then a >= b.
	assign full_sum = {1'b0, req.a} + {1'b0, req.b} + (INTEG_W + 1)'(req.cin);
	assign rsp.sum   = full_sum[INTEG_W-1:0];
	assign rsp.carry = full_sum[INTEG_W];

endmodule

// File: sv/ptl_seq.sv
module ptl_seq
	import ptl_pkg::*;
#(
	parameter int COUNT_WIDTH = 16,
	parameter int TIME_WIDTH  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  action_t               in_action,
	input  logic [TIME_WIDTH-1:0] in_time,
	input  thr_cfg_t              thr,
	output logic                  res_valid,
	input  logic                  res_ready,
	output ptl_res_t              res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_CMP,
		S_DIV,
		S_FILT,
		S_DONE
	} state_t;

	state_t                  state_q;
	action_t                 act_kind_q;
	logic [TIME_WIDTH-1:0]   now_q;
	logic [COUNT_WIDTH-1:0]  count_q;
	logic [INTEG_W-1:0]      integ_q;
	logic [TIME_WIDTH-1:0]   change_time_q;
	logic [TIME_WIDTH-1:0]   update_time_q;
	logic [7:0]              level_q;
	logic                    thrash_q;
	logic [INTEG_W-1:0]      mcand_q;
	logic [COUNT_WIDTH-1:0]  mplier_q;
	logic [TIME_WIDTH-1:0]   elapsed_q;
	logic [TIME_WIDTH-1:0]   rem_q;
	logic [2:0]              step_q;
	logic [7:0]              act_q;
	logic                    notify_q;
	logic                    underflow_q;

	alu_req_t                alu_req;
	alu_rsp_t                alu_rsp;
	logic [9:0]              blend;
	logic [7:0]              new_level;
	logic                    set_thrash;
	logic                    clr_thrash;
	logic [TIME_WIDTH-1:0]   since_change;

	ptl_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Ticks since the last count change, wrapped at the time width.
	assign since_change = in_time - change_time_q;

	always_comb begin
		unique case (state_q)
			S_CMP: begin
				alu_req.a   = integ_q;
				alu_req.b   = ~INTEG_W'(elapsed_q);
				alu_req.cin = 1'b1;
			end
			S_DIV: begin
				alu_req.a   = INTEG_W'({rem_q, 1'b0});
				alu_req.b   = ~INTEG_W'(elapsed_q);
				alu_req.cin = 1'b1;
			end
			default: begin
				alu_req.a   = integ_q;
				alu_req.b   = mcand_q;
				alu_req.cin = 1'b0;
			end
		endcase
	end

	// The level climbs by a 3:1 blend but drops straight to a lower activity.
	always_comb begin
		blend      = 10'({level_q, 1'b0}) + 10'(level_q) + 10'(act_q);
		new_level  = (act_q > level_q) ? blend[9:2] : act_q;
		set_thrash = (level_q < thr.thr_thrash) && (new_level >= thr.thr_thrash);
		clr_thrash = thrash_q && (level_q >= thr.thr_good) && (new_level < thr.thr_good);
	end

	assign in_ready      = (state_q == S_IDLE);
	assign res_valid     = (state_q == S_DONE);
	assign res.level     = level_q;
	assign res.thrashing = thrash_q;
	assign res.notify    = notify_q;
	assign res.activity  = act_q;
	assign res.underflow = underflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			act_kind_q    <= ACT_PAGE_START;
			now_q         <= '0;
			count_q       <= '0;
			integ_q       <= '0;
			change_time_q <= '0;
			update_time_q <= '0;
			level_q       <= '0;
			thrash_q      <= 1'b0;
			mcand_q       <= '0;
			mplier_q      <= '0;
			elapsed_q     <= '0;
			rem_q         <= '0;
			step_q        <= '0;
			act_q         <= '0;
			notify_q      <= 1'b0;
			underflow_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_kind_q  <= in_action;
						now_q       <= in_time;
						act_q       <= '0;
						notify_q    <= 1'b0;
						underflow_q <= 1'b0;
						if (in_action == ACT_RESTART) begin
							count_q       <= '0;
							integ_q       <= '0;
							change_time_q <= in_time;
							update_time_q <= in_time;
							state_q       <= S_DONE;
						end else begin
							mcand_q       <= INTEG_W'(since_change);
							mplier_q      <= count_q;
							elapsed_q     <= in_time - update_time_q;
							change_time_q <= in_time;
							state_q       <= S_MUL;
						end
					end
				end
				S_MUL: begin
					// Shift-and-add of count times ticks straight into the integral;
					// saturating each partial sum gives the same end value.
					if (mplier_q != '0) begin
						if (mplier_q[0]) begin
							integ_q <= alu_rsp.carry ? '1 : alu_rsp.sum;
						end
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
					end else begin
						unique case (act_kind_q)
							ACT_PAGE_START: begin
								if (!(&count_q)) begin
									count_q <= count_q + 1'b1;
								end
								state_q <= S_DONE;
							end
							ACT_PAGE_END: begin
								if (count_q == '0) begin
									underflow_q <= 1'b1;
								end else begin
									count_q <= count_q - 1'b1;
								end
								state_q <= S_DONE;
							end
							default: begin
								state_q <= (elapsed_q == '0) ? S_FILT : S_CMP;
							end
						endcase
					end
				end
				S_CMP: begin
					if (alu_rsp.carry) begin
						act_q   <= ACT_SATURATED;
						state_q <= S_FILT;
					end else begin
						// The integral is below the elapsed ticks, so it fits the time width.
						rem_q   <= integ_q[TIME_WIDTH-1:0];
						step_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (alu_rsp.carry) begin
						rem_q <= alu_rsp.sum[TIME_WIDTH-1:0];
					end else begin
						rem_q <= {rem_q[TIME_WIDTH-2:0], 1'b0};
					end
					act_q  <= {act_q[6:0], alu_rsp.carry};
					step_q <= step_q + 1'b1;
					if (&step_q) begin
						state_q <= S_FILT;
					end
				end
				S_FILT: begin
					level_q       <= new_level;
					integ_q       <= '0;
					update_time_q <= now_q;
					if (set_thrash) begin
						thrash_q <= 1'b1;
						notify_q <= 1'b1;
					end else if (clr_thrash) begin
						thrash_q <= 1'b0;
						notify_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/paging_thrash_level_monitor_unit.sv
// A restart event skips the arithmetic; a paging start or end runs the count-times-ticks
// shift-add over the bits of the paging count (at most COUNT_WIDTH), and an update may
// also run the compare and the eight divide steps; all of these run through the one
// shared 64-bit adder.
// One event is in work at a time; the next is taken once the result has moved to the
// output register. Reset is asynchronous and active low and clears all state at once.
`include "paging_thrash_level_monitor_unit_macros.svh"

module paging_thrash_level_monitor_unit
	import ptl_pkg::*;
#(
	parameter int COUNT_WIDTH = 16,
	parameter int TIME_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] current_time
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] thrash_level, [8] is_thrashing, [9] notify_change,
	// [17:10] paging_activity, [18] count_underflow, [23:19] zero
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	thr_cfg_t  thr_q;
	logic      res_valid;
	logic      res_ready;
	ptl_res_t  res;
	logic      m_valid_q;
	ptl_res_t  out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.thr_thrash <= THR_THRASH_RST;
			thr_q.thr_good   <= THR_GOOD_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_IDX_THRASH) begin
				thr_q.thr_thrash <= cfg_data;
			end else if (cfg_index == CFG_IDX_GOOD) begin
				thr_q.thr_good <= cfg_data;
			end
		end
	end

	ptl_seq #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (action_t'(s_tuser)),
		.in_time   (s_tdata[TIME_WIDTH-1:0]),
		.thr       (thr_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The output register frees up for a new result as the waiting beat is taken.
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			out_q     <= '0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b0, out_q.underflow, out_q.activity, out_q.notify,
		out_q.thrashing, out_q.level};

	`PTL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
	`PTL_ASSERT_NEXT(a_result_lands, res_valid && res_ready, m_tvalid, "result not registered")
	`PTL_ASSERT_NOW(a_underflow_alone, m_tvalid && m_tdata[18], m_tdata[17:9] == 9'd0, "underflow with update fields")

endmodule

// File: tb/sv/tb.sv
module tb;
	import ptl_pkg::*;

	localparam int         CYCLE_LIMIT   = 200_000;
	localparam int         RANDOM_EVENTS = 550;
	localparam int         PHASES        = 6;
	localparam int         COUNT_MAX     = 65535;
	localparam int         BURST_STARTS  = 8;
	localparam int         IDLE_PERCENT  = 12;
	localparam int         PRINT_CAP     = 100;
	// Register indexes that the block must ignore.
	localparam logic [1:0] CFG_IDX_SPARE_A = 2'd2;
	localparam logic [1:0] CFG_IDX_SPARE_B = 2'd3;

	typedef struct {
		action_t     act;
		logic [31:0] stamp;
		bit          typed;
		ptl_res_t    want;
	} plan_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data  = '0;

	// Predicted state of the monitor.
	logic [7:0]  thr_thrash_q = THR_THRASH_RST;
	logic [7:0]  thr_good_q   = THR_GOOD_RST;
	logic [15:0] pg_count     = '0;
	logic [63:0] pg_integral  = '0;
	logic [31:0] change_stamp = '0;
	logic [31:0] update_stamp = '0;
	logic [7:0]  level_q      = '0;
	logic        thrash_q     = 1'b0;

	ptl_res_t    results_due[$];
	plan_row_t   plan[$];
	logic [31:0] stamp_now = '0;
	bit          calm      = 1'b0;
	int          n_cycles  = 0;
	int          n_errors  = 0;
	int          n_results = 0;
	int          n_notify  = 0;
	int          n_underflow = 0;
	int          n_busy_avg  = 0;
	int          n_sent[4]   = '{0, 0, 0, 0};
	int          peak_count  = 0;

	paging_thrash_level_monitor_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", n_cycles,
				results_due.size());
			$display("simulation failed");
			$finish;
		end
	end

	// Adds count times elapsed ticks to the integral, saturating at the top.
	function automatic void fold_integral(logic [31:0] now);
		logic [31:0] dt;
		logic [64:0] sum;
		dt = now - change_stamp;
		sum = {1'b0, pg_integral} + 65'(pg_count) * 65'(dt);
		pg_integral = sum[64] ? '1 : sum[63:0];
		change_stamp = now;
	endfunction

	function automatic ptl_res_t predict_event(action_t act, logic [31:0] now);
		ptl_res_t    r;
		logic [31:0] elapsed;
		logic [7:0]  prev;
		logic [7:0]  nxt;
		logic [7:0]  activity;
		logic [9:0]  blend;
		r = '0;
		case (act)
		ACT_PAGE_START: begin
			fold_integral(now);
			if (pg_count != 16'(COUNT_MAX))
				pg_count++;
		end
		ACT_PAGE_END: begin
			fold_integral(now);
			if (pg_count == '0)
				r.underflow = 1'b1;
			else
				pg_count--;
		end
		ACT_UPDATE: begin
			elapsed = now - update_stamp;
			prev = level_q;
			fold_integral(now);
			if (elapsed == '0)
				activity = '0;
			else if (pg_integral >= 64'(elapsed))
				activity = ACT_SATURATED;
			else
				activity = 8'((pg_integral << 8) / 64'(elapsed));
			pg_integral = '0;
			nxt = activity;
			// The level climbs by a quarter step but drops straight to the activity.
			if (activity > prev) begin
				blend = 10'(prev) * 10'd3 + 10'(activity);
				nxt = blend[9:2];
			end
			level_q = nxt;
			if (prev < thr_thrash_q && nxt >= thr_thrash_q) begin
				thrash_q = 1'b1;
				r.notify = 1'b1;
			end else if (thrash_q && prev >= thr_good_q && nxt < thr_good_q) begin
				thrash_q = 1'b0;
				r.notify = 1'b1;
			end
			update_stamp = now;
			r.activity = activity;
		end
		default: begin
			pg_count = '0;
			pg_integral = '0;
			change_stamp = now;
			update_stamp = now;
		end
		endcase
		r.level = level_q;
		r.thrashing = thrash_q;
		return r;
	endfunction

	function automatic ptl_res_t outcome(logic [7:0] level, logic thrashing, logic notify,
			logic [7:0] activity, logic underflow);
		ptl_res_t r;
		r.level = level;
		r.thrashing = thrashing;
		r.notify = notify;
		r.activity = activity;
		r.underflow = underflow;
		return r;
	endfunction

	function automatic void add_row(action_t act, logic [31:0] stamp, bit typed = 1'b0,
			ptl_res_t want = '0);
		plan_row_t row;
		row.act = act;
		row.stamp = stamp;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		n_errors++;
		if (n_errors <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s is %0d, expected %0d", n_cycles, what, got,
				want);
	endtask

	task automatic send_event(action_t act, logic [31:0] stamp, bit typed, ptl_res_t typed_res);
		ptl_res_t r;
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = act;
		s_tdata = stamp;
		do @(posedge clk); while (!s_tready);
		r = predict_event(act, stamp);
		results_due.push_back(typed ? typed_res : r);
		n_sent[act]++;
		if (int'(pg_count) > peak_count)
			peak_count = pg_count;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_IDX_THRASH)
			thr_thrash_q = val;
		else if (idx == CFG_IDX_GOOD)
			thr_good_q = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stops the sender and waits for every outstanding result.
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	// Pages in and out around a target count, so that the average load sits near it.
	task automatic random_event(int unsigned target);
		action_t     act;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 3)
			act = ACT_RESTART;
		else if (pick < 28)
			act = ACT_UPDATE;
		else if (pg_count >= target)
			act = (pick < 75) ? ACT_PAGE_END : ACT_PAGE_START;
		else
			act = (pick < 75) ? ACT_PAGE_START : ACT_PAGE_END;
		pick = $urandom_range(99);
		if (pick >= 95)
			stamp_now = $urandom();
		else if (pick >= 80)
			stamp_now += $urandom_range(32'h0001_0000, 1);
		else if (pick >= 15)
			stamp_now += $urandom_range(60, 1);
		send_event(act, stamp_now, 1'b0, '0);
	endtask

	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);

	always @(posedge clk) begin : check_results
		ptl_res_t got;
		ptl_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = ptl_res_t'(m_tdata[18:0]);
			if (results_due.size() == 0) begin
				report_mismatch("result beat with nothing outstanding, level", got.level, 0);
			end else begin
				want = results_due.pop_front();
				n_results++;
				if (want.notify)
					n_notify++;
				if (want.underflow)
					n_underflow++;
				if (want.activity == ACT_SATURATED)
					n_busy_avg++;
				if (got.level != want.level)
					report_mismatch("thrash_level", got.level, want.level);
				if (got.thrashing != want.thrashing)
					report_mismatch("is_thrashing", got.thrashing, want.thrashing);
				if (got.notify != want.notify)
					report_mismatch("notify_change", got.notify, want.notify);
				if (got.activity != want.activity)
					report_mismatch("paging_activity", got.activity, want.activity);
				if (got.underflow != want.underflow)
					report_mismatch("count_underflow", got.underflow, want.underflow);
				if (m_tdata[23:19] != '0)
					report_mismatch("padding bits", m_tdata[23:19], 0);
			end
		end
	end

	initial begin : stimulus
		logic [7:0] thr_plan[PHASES];
		logic [7:0] good_plan[PHASES];
		thr_plan  = '{8'd255, 8'd0,   8'd0, 8'd255, 8'd180, 8'd0};
		good_plan = '{8'd0,   8'd255, 8'd0, 8'd255, 8'd120, 8'd0};
		thr_plan[PHASES-1] = 8'($urandom_range(255));
		good_plan[PHASES-1] = 8'($urandom_range(thr_plan[PHASES-1]));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset thresholds hold here: thrashing from 200, cleared below 150.
		add_row(ACT_UPDATE,     32'd0,   1'b1, outcome(8'd0, 1'b0, 1'b0, 8'd0, 1'b0));
		add_row(ACT_PAGE_END,   32'd5,   1'b1, outcome(8'd0, 1'b0, 1'b0, 8'd0, 1'b1));
		add_row(ACT_PAGE_START, 32'd10,  1'b1, outcome(8'd0, 1'b0, 1'b0, 8'd0, 1'b0));
		add_row(ACT_UPDATE,     32'd20,  1'b1, outcome(8'd32, 1'b0, 1'b0, 8'd128, 1'b0));
		add_row(ACT_UPDATE,     32'd40,  1'b1, outcome(8'd87, 1'b0, 1'b0, 8'd255, 1'b0));
		add_row(ACT_UPDATE,     32'd60);
		add_row(ACT_UPDATE,     32'd80);
		add_row(ACT_UPDATE,     32'd100);
		add_row(ACT_UPDATE,     32'd120);
		add_row(ACT_PAGE_END,   32'd130);
		add_row(ACT_UPDATE,     32'd150);
		add_row(ACT_PAGE_START, 32'd150);
		add_row(ACT_PAGE_START, 32'd150);
		add_row(ACT_UPDATE,     32'd150, 1'b1, outcome(8'd0, 1'b0, 1'b0, 8'd0, 1'b0));
		add_row(ACT_RESTART,    32'hFFFF_FFF0, 1'b1, outcome(8'd0, 1'b0, 1'b0, 8'd0, 1'b0));
		add_row(ACT_PAGE_START, 32'hFFFF_FFF8);
		add_row(ACT_UPDATE,     32'h0000_0008);
		add_row(ACT_PAGE_END,   32'h0000_0010);
		add_row(ACT_PAGE_END,   32'h0000_0020);
		add_row(ACT_RESTART,    32'h0000_0020);
		add_row(ACT_RESTART,    32'h0000_0020);
		add_row(ACT_UPDATE,     32'h0000_0020);
		add_row(ACT_PAGE_START, 32'hFFFF_FFFF);
		add_row(ACT_UPDATE,     32'h0000_0000);
		foreach (plan[i])
			send_event(plan[i].act, plan[i].stamp, plan[i].typed, plan[i].want);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				write_reg(CFG_IDX_SPARE_A, 8'hFF);
				write_reg(CFG_IDX_SPARE_B, 8'h00);
			end
			if (ph % 2 == 0) begin
				write_reg(CFG_IDX_THRASH, thr_plan[ph]);
				write_reg(CFG_IDX_GOOD, good_plan[ph]);
			end else begin
				write_reg(CFG_IDX_GOOD, good_plan[ph]);
				write_reg(CFG_IDX_THRASH, thr_plan[ph]);
			end
			// One phase runs with neither side ever idling.
			calm = (ph == 2);
			for (int n = 0; n < RANDOM_EVENTS / PHASES; n++)
				random_event((ph % 3 == 0) ? 1 : $urandom_range(4, 1));
			settle();
		end

		// Build up a handful of paging threads, then step the clock almost a full turn.
		write_reg(CFG_IDX_THRASH, THR_THRASH_RST);
		write_reg(CFG_IDX_GOOD, THR_GOOD_RST);
		calm = 1'b1;
		stamp_now += 32'd100;
		send_event(ACT_RESTART, stamp_now, 1'b0, '0);
		for (int n = 0; n < BURST_STARTS; n++) begin
			stamp_now += $urandom_range(3, 1);
			send_event(ACT_PAGE_START, stamp_now, 1'b0, '0);
		end
		stamp_now += 32'hFFFF_FFFF;
		send_event(ACT_PAGE_START, stamp_now, 1'b0, '0);
		send_event(ACT_UPDATE, stamp_now + 32'd7, 1'b0, '0);
		send_event(ACT_PAGE_END, stamp_now + 32'd9, 1'b0, '0);
		send_event(ACT_UPDATE, stamp_now + 32'd9, 1'b0, '0);
		send_event(ACT_RESTART, stamp_now + 32'd11, 1'b0, '0);
		calm = 1'b0;
		settle();
		repeat (40) @(posedge clk);

		$display("ran %0d paging starts, %0d ends, %0d updates and %0d restarts; %0d results checked",
			n_sent[ACT_PAGE_START], n_sent[ACT_PAGE_END], n_sent[ACT_UPDATE],
			n_sent[ACT_RESTART], n_results);
		$display("saw %0d threshold crossings, %0d underflows, %0d saturated averages, peak count %0d",
			n_notify, n_underflow, n_busy_avg, peak_count);
		if (n_errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
